// ----- hdl/stun_message_attribute_parser_defines.svh -----
// Assertion macros shared by the parser RTL.
`ifndef STUN_MESSAGE_ATTRIBUTE_PARSER_DEFINES_SVH
`define STUN_MESSAGE_ATTRIBUTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define STUN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define STUN_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define STUN_ASSERT(label, clk, rst_n, prop, msg)
`define STUN_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/stun_pkg.sv -----
package stun_pkg;

	localparam logic [16:0] HDR_BYTES = 17'd20;
	localparam logic [16:0] TXID_START = 17'd8;

	localparam logic [15:0] ATTR_USERNAME = 16'h0006;
	localparam logic [15:0] ATTR_USE_CAND = 16'h0025;
	localparam logic [15:0] ATTR_CONTROLLED = 16'h8029;
	localparam logic [15:0] ATTR_CONTROLLING = 16'h802A;

	localparam logic [7:0] COLON_CHAR = 8'h3A;

	localparam logic [1:0] KIND_TXID = 2'd0;
	localparam logic [1:0] KIND_USER = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic        after_colon;
		logic [15:0] message_kind;
		logic [1:0]  status;
		logic        use_candidate;
		logic        ice_controlled;
		logic        ice_controlling;
		logic        colon_seen;
	} result_t;

endpackage

// ----- hdl/stun_byte_if.sv -----
interface stun_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [16:0] packet_length;

	modport source (
		output valid, data_byte, first_byte, last_byte, packet_length,
		input  ready
	);
	modport sink (
		input  valid, data_byte, first_byte, last_byte, packet_length,
		output ready
	);
endinterface

// ----- hdl/stun_result_if.sv -----
interface stun_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        after_colon;
	logic [15:0] message_kind;
	logic [1:0]  status;
	logic        use_candidate;
	logic        ice_controlled;
	logic        ice_controlling;
	logic        colon_seen;

	modport source (
		output valid, kind, out_byte, after_colon, message_kind, status,
		       use_candidate, ice_controlled, ice_controlling, colon_seen,
		input  ready
	);
	modport sink (
		input  valid, kind, out_byte, after_colon, message_kind, status,
		       use_candidate, ice_controlled, ice_controlling, colon_seen,
		output ready
	);
endinterface

// ----- hdl/stun_message_attribute_parser.sv -----
// A result is registered in the pair stage with its byte transfer on pkt, then moves into the
//   output register when that is empty or being drained, and is presented on res from there.
// Throughput: one byte per cycle while the pair stage drains; a last byte that also yields a data
//   byte puts two results into the pair stage, which drain through the single output register.
// Reset (arst_n low, asynchronous): no packet open, parse state cleared, both result
//   stages empty; bytes without first_byte are dropped until a packet opens.
`include "stun_message_attribute_parser_defines.svh"

module stun_message_attribute_parser (
	input logic          clk,
	input logic          arst_n,
	stun_byte_if.sink    pkt,
	stun_result_if.source res
);
	import stun_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ATTR_HDR,
		PH_VALUE,
		PH_PAD,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic use_cand;
		logic ctld;
		logic ctlg;
		logic colon;
		logic open;
	} flags_t;

	// Parse state
	logic [16:0] pos_q, exp_q;
	phase_t      phase_q;
	logic [15:0] htype_q, hlen_q, atype_q, arem_q;
	logic [1:0]  pad_q;
	flags_t      flags_q;
	logic [1:0]  err_q;

	// State as seen by the incoming byte (after a packet restart)
	logic [16:0] b_pos, b_exp;
	phase_t      b_phase;
	logic [15:0] b_htype, b_hlen, b_atype, b_arem;
	logic [1:0]  b_pad;
	flags_t      b_flags;
	logic [1:0]  b_err;

	// Next state
	logic [16:0] nx_pos;
	phase_t      nx_phase;
	logic [15:0] nx_htype, nx_hlen, nx_atype, nx_arem;
	logic [1:0]  nx_pad;
	flags_t      nx_flags;
	logic [1:0]  nx_err;

	logic [15:0] rem_word;
	logic [16:0] bytes_left;
	logic        short_pkt;

	// Results of the current byte: a data byte and a summary
	logic        dat_v, sum_v;
	result_t     dat, sum;

	// Pair stage and output register
	logic        dat_s1_v, sum_s1_v;
	result_t     dat_s1, sum_s1;
	logic        out_v_q;
	result_t     out_q;

	logic        acc, out_free;

	assign short_pkt = pkt.packet_length < HDR_BYTES;
	assign rem_word = {b_arem[7:0], pkt.data_byte};
	assign bytes_left = b_exp - b_pos;

	// Restart the parse on a first byte, else continue from the registers
	always_comb begin
		if (pkt.first_byte) begin
			b_pos = '0;
			b_exp = pkt.packet_length;
			b_phase = short_pkt ? PH_SKIP : PH_HEADER;
			b_htype = '0;
			b_hlen = '0;
			b_atype = '0;
			b_arem = '0;
			b_pad = '0;
			b_flags = '{use_cand: 1'b0, ctld: 1'b0, ctlg: 1'b0, colon: 1'b0, open: 1'b1};
			b_err = short_pkt ? ST_SHORT : ST_OK;
		end else begin
			b_pos = pos_q;
			b_exp = exp_q;
			b_phase = phase_q;
			b_htype = htype_q;
			b_hlen = hlen_q;
			b_atype = atype_q;
			b_arem = arem_q;
			b_pad = pad_q;
			b_flags = flags_q;
			b_err = err_q;
		end
	end

	// Byte handling
	always_comb begin
		nx_pos = b_pos;
		nx_phase = b_phase;
		nx_htype = b_htype;
		nx_hlen = b_hlen;
		nx_atype = b_atype;
		nx_arem = b_arem;
		nx_pad = b_pad;
		nx_flags = b_flags;
		nx_err = b_err;
		dat_v = 1'b0;
		dat = '0;
		sum_v = 1'b0;
		sum = '0;

		if (b_flags.open && b_pos < b_exp) begin
			nx_pos = b_pos + 17'd1;
			unique case (b_phase)
				PH_HEADER: begin
					if (b_pos < 17'd2) begin
						nx_htype = {b_htype[7:0], pkt.data_byte};
					end else if (b_pos < 17'd4) begin
						nx_hlen = {b_hlen[7:0], pkt.data_byte};
					end
					if (b_pos == 17'd3 && b_exp != HDR_BYTES + {1'b0, nx_hlen}) begin
						nx_err = ST_MISMATCH;
					end
					// Transaction id occupies header bytes 8 through 19
					if (b_pos >= TXID_START) begin
						dat_v = 1'b1;
						dat.kind = KIND_TXID;
						dat.out_byte = pkt.data_byte;
					end
					if (b_pos == HDR_BYTES - 17'd1) begin
						nx_phase = (nx_err != ST_OK) ? PH_SKIP : PH_ATTR_HDR;
					end
				end
				PH_ATTR_HDR: begin
					// Attributes start on a 4-byte boundary, so the low position bits index
					// the attribute header byte; drop a tail under 4 bytes
					if (b_pos[1:0] == 2'd0 && bytes_left < 17'd4) begin
						nx_phase = PH_SKIP;
					end else begin
						if (!b_pos[1]) begin
							nx_atype = {b_atype[7:0], pkt.data_byte};
						end else begin
							nx_arem = rem_word;
						end
						if (b_pos[1:0] == 2'd3) begin
							if (bytes_left - 17'd1 < {1'b0, rem_word}) begin
								nx_err = ST_OVERRUN;
								nx_phase = PH_SKIP;
							end else begin
								case (b_atype)
									ATTR_USERNAME:    nx_flags.colon = 1'b0;
									ATTR_USE_CAND:    nx_flags.use_cand = 1'b1;
									ATTR_CONTROLLED:  nx_flags.ctld = 1'b1;
									ATTR_CONTROLLING: nx_flags.ctlg = 1'b1;
									default:          ;
								endcase
								nx_pad = 2'd0 - rem_word[1:0];
								if (rem_word == 16'd0) begin
									nx_phase = (nx_pad != 2'd0) ? PH_PAD : PH_ATTR_HDR;
								end else begin
									nx_phase = PH_VALUE;
								end
							end
						end
					end
				end
				PH_VALUE: begin
					if (b_atype == ATTR_USERNAME) begin
						dat_v = 1'b1;
						dat.kind = KIND_USER;
						dat.out_byte = pkt.data_byte;
						dat.after_colon = b_flags.colon;
						if (pkt.data_byte == COLON_CHAR) begin
							nx_flags.colon = 1'b1;
						end
					end
					nx_arem = b_arem - 16'd1;
					if (nx_arem == 16'd0) begin
						nx_phase = (b_pad != 2'd0) ? PH_PAD : PH_ATTR_HDR;
					end
				end
				PH_PAD: begin
					nx_pad = b_pad - 2'd1;
					if (nx_pad == 2'd0) begin
						nx_phase = PH_ATTR_HDR;
					end
				end
				PH_SKIP: ;
				default: ;
			endcase
		end

		// Close the packet and report on its last byte
		if (b_flags.open && pkt.last_byte) begin
			sum_v = 1'b1;
			sum.kind = KIND_SUMMARY;
			sum.message_kind = nx_htype;
			sum.status = nx_err;
			sum.use_candidate = nx_flags.use_cand;
			sum.ice_controlled = nx_flags.ctld;
			sum.ice_controlling = nx_flags.ctlg;
			sum.colon_seen = nx_flags.colon;
			nx_flags.open = 1'b0;
		end
	end

	// Output register takes a result whenever it is empty or being drained
	assign out_free = !out_v_q || res.ready;
	// Take a byte only if the pair stage is empty after this cycle
	assign pkt.ready = (!dat_s1_v && !sum_s1_v) || (out_free && (dat_s1_v ^ sum_s1_v));
	assign acc = pkt.valid && pkt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			exp_q <= '0;
			phase_q <= PH_HEADER;
			htype_q <= '0;
			hlen_q <= '0;
			atype_q <= '0;
			arem_q <= '0;
			pad_q <= '0;
			flags_q <= '0;
			err_q <= ST_OK;
			dat_s1_v <= 1'b0;
			sum_s1_v <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			// Advance the pair stage into the output register, data byte first
			if (out_free) begin
				out_v_q <= dat_s1_v || sum_s1_v;
				if (dat_s1_v) begin
					dat_s1_v <= 1'b0;
				end else begin
					sum_s1_v <= 1'b0;
				end
			end
			if (acc) begin
				pos_q <= nx_pos;
				exp_q <= b_exp;
				phase_q <= nx_phase;
				htype_q <= nx_htype;
				hlen_q <= nx_hlen;
				atype_q <= nx_atype;
				arem_q <= nx_arem;
				pad_q <= nx_pad;
				flags_q <= nx_flags;
				err_q <= nx_err;
				dat_s1_v <= dat_v;
				sum_s1_v <= sum_v;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			dat_s1 <= dat;
			sum_s1 <= sum;
		end
		if (out_free) begin
			out_q <= dat_s1_v ? dat_s1 : sum_s1;
		end
	end

	assign res.valid = out_v_q;
	assign res.kind = out_q.kind;
	assign res.out_byte = out_q.out_byte;
	assign res.after_colon = out_q.after_colon;
	assign res.message_kind = out_q.message_kind;
	assign res.status = out_q.status;
	assign res.use_candidate = out_q.use_candidate;
	assign res.ice_controlled = out_q.ice_controlled;
	assign res.ice_controlling = out_q.ice_controlling;
	assign res.colon_seen = out_q.colon_seen;

	`STUN_ASSERT(a_summary_on_last, clk, arst_n, pkt.valid && pkt.ready && pkt.last_byte && (pkt.first_byte || flags_q.open) |=> sum_s1_v, "last byte of an open packet left no summary")
	`STUN_ASSERT_NEVER(a_pad_nonzero, clk, arst_n, phase_q == PH_PAD && pad_q == 2'd0, "padding phase with no padding left")
	`STUN_ASSERT_NEVER(a_pos_bound, clk, arst_n, flags_q.open && pos_q > exp_q, "byte position ran past packet length")
	`STUN_ASSERT_NEVER(a_data_kind, clk, arst_n, dat_s1_v && dat_s1.kind == KIND_SUMMARY, "summary held in data byte slot")

endmodule
